>>> src/assert_macros.svh
// Assertion macros used by the frame sender RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define FSK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define FSK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/fsk_pws_pkg.sv
// Types, codes and reset values of the pulse-width FSK frame sender.
`default_nettype none

package fsk_pws_pkg;

    localparam int TICK_W = 16;
    localparam int FREQ_W = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int BITS_LEFT_W = 4;

    localparam logic [BITS_LEFT_W-1:0] BITS_PER_BYTE = 4'd8;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_MARK  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_SPACE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_MARK   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_MARK  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_MARK   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_SPACE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARK_FREQ  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPACE_FREQ = 3'd7;

    localparam logic [TICK_W-1:0] RST_HEAD_MARK  = 16'd30;
    localparam logic [TICK_W-1:0] RST_GAP_SPACE  = 16'd5;
    localparam logic [TICK_W-1:0] RST_ONE_MARK   = 16'd20;
    localparam logic [TICK_W-1:0] RST_ZERO_MARK  = 16'd10;
    localparam logic [TICK_W-1:0] RST_END_MARK   = 16'd50;
    localparam logic [TICK_W-1:0] RST_END_SPACE  = 16'd20;
    localparam logic [FREQ_W-1:0] RST_MARK_FREQ  = 24'd10000;
    localparam logic [FREQ_W-1:0] RST_SPACE_FREQ = 24'd15000;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_HEAD_MARK  = 7'b0000010,
        PH_HEAD_SPACE = 7'b0000100,
        PH_BIT_MARK   = 7'b0001000,
        PH_BIT_SPACE  = 7'b0010000,
        PH_END_MARK   = 7'b0100000,
        PH_END_SPACE  = 7'b1000000
    } phase_t;

    // A programmed length of zero behaves as one tick.
    function automatic logic [TICK_W-1:0] dur_f(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

>>> src/fsk_pws_if.sv
// Request and result channel interfaces of the frame sender.
`default_nettype none

interface fsk_pws_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output kind, output data_byte, output last_byte,
                    input ready);
    modport sink (input valid, input kind, input data_byte, input last_byte,
                  output ready);
endinterface

interface fsk_pws_res_if;
    logic                            valid;
    logic                            ready;
    logic [fsk_pws_pkg::FREQ_W-1:0]  tone_freq;
    logic                            tone_is_mark;
    logic                            busy_res;
    logic                            accepted;

    modport source (output valid, output tone_freq, output tone_is_mark,
                    output busy_res, output accepted, input ready);
    modport sink (input valid, input tone_freq, input tone_is_mark,
                  input busy_res, input accepted, output ready);
endinterface

`default_nettype wire

>>> src/fsk_pulse_width_frame_sender_core.sv
// Top level of the pulse-width FSK frame sender: sequencer and result register.
`default_nettype none
`include "assert_macros.svh"

// The sender takes one word per clock cycle on the request channel: ticks, bytes
// and end requests act on the phase sequencer in the cycle they are accepted, bytes
// and ends only while idle; each word yields one result word in the result register.
// The request channel is ready whenever the result register is empty or is being
// drained in the same cycle, so the sustained rate is one word per cycle unless
// the result sink stalls. Configuration writes are meant for idle periods only.
module fsk_pulse_width_frame_sender_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [fsk_pws_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [fsk_pws_pkg::FREQ_W-1:0]        cfg_data,
    fsk_pws_req_if.sink                                req,
    fsk_pws_res_if.source                              res
);

    logic [fsk_pws_pkg::TICK_W-1:0] head_mark_reg;
    logic [fsk_pws_pkg::TICK_W-1:0] gap_space_reg;
    logic [fsk_pws_pkg::TICK_W-1:0] one_mark_reg;
    logic [fsk_pws_pkg::TICK_W-1:0] zero_mark_reg;
    logic [fsk_pws_pkg::TICK_W-1:0] end_mark_reg;
    logic [fsk_pws_pkg::TICK_W-1:0] end_space_reg;
    logic [fsk_pws_pkg::FREQ_W-1:0] mark_freq_reg;
    logic [fsk_pws_pkg::FREQ_W-1:0] space_freq_reg;

    fsk_pws_pkg::phase_t                 phase_reg, phase_next;
    logic [fsk_pws_pkg::TICK_W-1:0]      count_reg, count_next;
    logic [7:0]                          shift_reg, shift_next;
    logic [fsk_pws_pkg::BITS_LEFT_W-1:0] bits_left_reg, bits_left_next;
    logic                                end_pending_reg, end_pending_next;
    logic                                accepted_next;
    logic                                mark_next;

    logic                                res_valid_reg;
    logic [fsk_pws_pkg::FREQ_W-1:0]      res_freq_reg;
    logic                                res_mark_reg;
    logic                                res_busy_reg;
    logic                                res_accepted_reg;

    logic req_fire;

    assign req.ready = !res_valid_reg || res.ready;
    assign req_fire  = req.valid && req.ready;

    assign res.valid        = res_valid_reg;
    assign res.tone_freq    = res_freq_reg;
    assign res.tone_is_mark = res_mark_reg;
    assign res.busy_res     = res_busy_reg;
    assign res.accepted     = res_accepted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_mark_reg  <= fsk_pws_pkg::RST_HEAD_MARK;
            gap_space_reg  <= fsk_pws_pkg::RST_GAP_SPACE;
            one_mark_reg   <= fsk_pws_pkg::RST_ONE_MARK;
            zero_mark_reg  <= fsk_pws_pkg::RST_ZERO_MARK;
            end_mark_reg   <= fsk_pws_pkg::RST_END_MARK;
            end_space_reg  <= fsk_pws_pkg::RST_END_SPACE;
            mark_freq_reg  <= fsk_pws_pkg::RST_MARK_FREQ;
            space_freq_reg <= fsk_pws_pkg::RST_SPACE_FREQ;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fsk_pws_pkg::CFG_HEAD_MARK:  head_mark_reg  <= cfg_data[15:0];
                fsk_pws_pkg::CFG_GAP_SPACE:  gap_space_reg  <= cfg_data[15:0];
                fsk_pws_pkg::CFG_ONE_MARK:   one_mark_reg   <= cfg_data[15:0];
                fsk_pws_pkg::CFG_ZERO_MARK:  zero_mark_reg  <= cfg_data[15:0];
                fsk_pws_pkg::CFG_END_MARK:   end_mark_reg   <= cfg_data[15:0];
                fsk_pws_pkg::CFG_END_SPACE:  end_space_reg  <= cfg_data[15:0];
                fsk_pws_pkg::CFG_MARK_FREQ:  mark_freq_reg  <= cfg_data;
                fsk_pws_pkg::CFG_SPACE_FREQ: space_freq_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [7:0]                          shifted;
        logic [fsk_pws_pkg::BITS_LEFT_W-1:0] bits_dec;

        phase_next       = phase_reg;
        count_next       = count_reg;
        shift_next       = shift_reg;
        bits_left_next   = bits_left_reg;
        end_pending_next = end_pending_reg;
        accepted_next    = 1'b0;
        shifted          = {shift_reg[6:0], 1'b0};
        bits_dec         = (bits_left_reg != '0) ? bits_left_reg - 4'd1 : '0;

        unique case (req.kind)
            fsk_pws_pkg::KIND_TICK:
            begin
                if (phase_reg != fsk_pws_pkg::PH_IDLE)
                begin
                    if (count_reg > 16'd1)
                    begin
                        count_next = count_reg - 16'd1;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            fsk_pws_pkg::PH_HEAD_MARK:
                            begin
                                phase_next = fsk_pws_pkg::PH_HEAD_SPACE;
                                count_next = fsk_pws_pkg::dur_f(gap_space_reg);
                            end
                            fsk_pws_pkg::PH_HEAD_SPACE:
                            begin
                                bits_left_next = fsk_pws_pkg::BITS_PER_BYTE;
                                phase_next     = fsk_pws_pkg::PH_BIT_MARK;
                                count_next     = shift_reg[7] ?
                                                 fsk_pws_pkg::dur_f(one_mark_reg) :
                                                 fsk_pws_pkg::dur_f(zero_mark_reg);
                            end
                            fsk_pws_pkg::PH_BIT_MARK:
                            begin
                                phase_next = fsk_pws_pkg::PH_BIT_SPACE;
                                count_next = fsk_pws_pkg::dur_f(gap_space_reg);
                            end
                            fsk_pws_pkg::PH_BIT_SPACE:
                            begin
                                shift_next     = shifted;
                                bits_left_next = bits_dec;
                                if (bits_dec != '0)
                                begin
                                    phase_next = fsk_pws_pkg::PH_BIT_MARK;
                                    count_next = shifted[7] ?
                                                 fsk_pws_pkg::dur_f(one_mark_reg) :
                                                 fsk_pws_pkg::dur_f(zero_mark_reg);
                                end
                                else if (end_pending_reg)
                                begin
                                    end_pending_next = 1'b0;
                                    phase_next       = fsk_pws_pkg::PH_END_MARK;
                                    count_next       = fsk_pws_pkg::dur_f(end_mark_reg);
                                end
                                else
                                begin
                                    phase_next = fsk_pws_pkg::PH_IDLE;
                                    count_next = '0;
                                end
                            end
                            fsk_pws_pkg::PH_END_MARK:
                            begin
                                phase_next = fsk_pws_pkg::PH_END_SPACE;
                                count_next = fsk_pws_pkg::dur_f(end_space_reg);
                            end
                            default:
                            begin
                                phase_next = fsk_pws_pkg::PH_IDLE;
                                count_next = '0;
                            end
                        endcase
                    end
                end
            end
            fsk_pws_pkg::KIND_BYTE:
            begin
                if (phase_reg == fsk_pws_pkg::PH_IDLE)
                begin
                    shift_next       = req.data_byte;
                    bits_left_next   = fsk_pws_pkg::BITS_PER_BYTE;
                    end_pending_next = req.last_byte;
                    phase_next       = fsk_pws_pkg::PH_HEAD_MARK;
                    count_next       = fsk_pws_pkg::dur_f(head_mark_reg);
                    accepted_next    = 1'b1;
                end
            end
            fsk_pws_pkg::KIND_END:
            begin
                if (phase_reg == fsk_pws_pkg::PH_IDLE)
                begin
                    end_pending_next = 1'b0;
                    phase_next       = fsk_pws_pkg::PH_END_MARK;
                    count_next       = fsk_pws_pkg::dur_f(end_mark_reg);
                    accepted_next    = 1'b1;
                end
            end
            default: ;
        endcase

        mark_next = (phase_next == fsk_pws_pkg::PH_HEAD_MARK) ||
                    (phase_next == fsk_pws_pkg::PH_BIT_MARK) ||
                    (phase_next == fsk_pws_pkg::PH_END_MARK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= fsk_pws_pkg::PH_IDLE;
            count_reg       <= '0;
            shift_reg       <= '0;
            bits_left_reg   <= '0;
            end_pending_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                phase_reg       <= phase_next;
                count_reg       <= count_next;
                shift_reg       <= shift_next;
                bits_left_reg   <= bits_left_next;
                end_pending_reg <= end_pending_next;
                res_valid_reg   <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            res_freq_reg     <= mark_next ? mark_freq_reg : space_freq_reg;
            res_mark_reg     <= mark_next;
            res_busy_reg     <= (phase_next != fsk_pws_pkg::PH_IDLE);
            res_accepted_reg <= accepted_next;
        end
    end

    `FSK_ASSERT(a_idle_count_zero,
        (phase_reg == fsk_pws_pkg::PH_IDLE) |-> (count_reg == '0),
        "Idle phase with a nonzero tick count.")
    `FSK_ASSERT(a_active_count_nonzero,
        (phase_reg != fsk_pws_pkg::PH_IDLE) |-> (count_reg != '0),
        "Active phase with a tick count of zero.")
    `FSK_ASSERT_ALWAYS(a_bits_left_range,
        bits_left_reg <= fsk_pws_pkg::BITS_PER_BYTE,
        "Bit counter beyond eight.")
    `FSK_ASSERT(a_accept_means_busy,
        (res_valid_reg && res_accepted_reg) |-> res_busy_reg,
        "Accepted request reported without busy.")

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the pulse-width FSK frame sender core with a tone predictor.
module tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last_byte;
    } tone_request_t;

    typedef struct packed {
        logic [fsk_pws_pkg::FREQ_W-1:0] tone_freq;
        logic                           tone_is_mark;
        logic                           busy_res;
        logic                           accepted;
    } tone_result_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [fsk_pws_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fsk_pws_pkg::FREQ_W-1:0]      cfg_data;

    fsk_pws_req_if req_ch ();
    fsk_pws_res_if res_ch ();

    fsk_pulse_width_frame_sender_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    tone_request_t request_queue[$];
    tone_result_t  expected_tones[$];

    logic [fsk_pws_pkg::TICK_W-1:0] head_len;
    logic [fsk_pws_pkg::TICK_W-1:0] gap_len;
    logic [fsk_pws_pkg::TICK_W-1:0] one_len;
    logic [fsk_pws_pkg::TICK_W-1:0] zero_len;
    logic [fsk_pws_pkg::TICK_W-1:0] end_len;
    logic [fsk_pws_pkg::TICK_W-1:0] end_gap_len;
    logic [fsk_pws_pkg::FREQ_W-1:0] mark_hz;
    logic [fsk_pws_pkg::FREQ_W-1:0] space_hz;

    fsk_pws_pkg::phase_t                 line_phase;
    logic [fsk_pws_pkg::TICK_W-1:0]      ticks_left;
    logic [7:0]                          bits_out;
    logic [fsk_pws_pkg::BITS_LEFT_W-1:0] bits_to_go;
    logic                                end_after;

    bit no_gaps;
    int fail_count;
    int words_checked;
    int bytes_taken;
    int ends_taken;
    int refused_count;
    int setting_count;

    function automatic logic [fsk_pws_pkg::TICK_W-1:0] at_least_one(
        input logic [fsk_pws_pkg::TICK_W-1:0] v);
        return (v == '0) ? fsk_pws_pkg::TICK_W'(1) : v;
    endfunction

    function automatic void enter_phase(input fsk_pws_pkg::phase_t p);
        line_phase = p;
        case (p)
            fsk_pws_pkg::PH_HEAD_MARK:  ticks_left = at_least_one(head_len);
            fsk_pws_pkg::PH_HEAD_SPACE: ticks_left = at_least_one(gap_len);
            fsk_pws_pkg::PH_BIT_MARK:   ticks_left = bits_out[7] ? at_least_one(one_len)
                                                                 : at_least_one(zero_len);
            fsk_pws_pkg::PH_BIT_SPACE:  ticks_left = at_least_one(gap_len);
            fsk_pws_pkg::PH_END_MARK:   ticks_left = at_least_one(end_len);
            fsk_pws_pkg::PH_END_SPACE:  ticks_left = at_least_one(end_gap_len);
            default:
            begin
                line_phase = fsk_pws_pkg::PH_IDLE;
                ticks_left = '0;
            end
        endcase
    endfunction

    function automatic void next_phase();
        case (line_phase)
            fsk_pws_pkg::PH_HEAD_MARK: enter_phase(fsk_pws_pkg::PH_HEAD_SPACE);
            fsk_pws_pkg::PH_HEAD_SPACE:
            begin
                bits_to_go = fsk_pws_pkg::BITS_PER_BYTE;
                enter_phase(fsk_pws_pkg::PH_BIT_MARK);
            end
            fsk_pws_pkg::PH_BIT_MARK: enter_phase(fsk_pws_pkg::PH_BIT_SPACE);
            fsk_pws_pkg::PH_BIT_SPACE:
            begin
                bits_out = bits_out << 1;
                bits_to_go = (bits_to_go != '0) ? bits_to_go - 1'b1 : '0;
                if (bits_to_go != '0)
                    enter_phase(fsk_pws_pkg::PH_BIT_MARK);
                else if (end_after)
                begin
                    end_after = 1'b0;
                    enter_phase(fsk_pws_pkg::PH_END_MARK);
                end
                else
                    enter_phase(fsk_pws_pkg::PH_IDLE);
            end
            fsk_pws_pkg::PH_END_MARK: enter_phase(fsk_pws_pkg::PH_END_SPACE);
            default: enter_phase(fsk_pws_pkg::PH_IDLE);
        endcase
    endfunction

    function automatic void predict_tone(input logic [1:0] kind, input logic [7:0] data,
                                         input logic last);
        tone_result_t r;
        logic         took;
        logic         mark;
        took = 1'b0;
        case (kind)
            fsk_pws_pkg::KIND_TICK:
            begin
                if (line_phase != fsk_pws_pkg::PH_IDLE)
                begin
                    if (ticks_left > 1)
                        ticks_left = ticks_left - 1'b1;
                    else
                        next_phase();
                end
            end
            fsk_pws_pkg::KIND_BYTE:
            begin
                if (line_phase == fsk_pws_pkg::PH_IDLE)
                begin
                    bits_out = data;
                    bits_to_go = fsk_pws_pkg::BITS_PER_BYTE;
                    end_after = last;
                    enter_phase(fsk_pws_pkg::PH_HEAD_MARK);
                    took = 1'b1;
                    bytes_taken++;
                end
                else
                    refused_count++;
            end
            fsk_pws_pkg::KIND_END:
            begin
                if (line_phase == fsk_pws_pkg::PH_IDLE)
                begin
                    end_after = 1'b0;
                    enter_phase(fsk_pws_pkg::PH_END_MARK);
                    took = 1'b1;
                    ends_taken++;
                end
                else
                    refused_count++;
            end
            default: ;
        endcase
        mark = line_phase inside {fsk_pws_pkg::PH_HEAD_MARK, fsk_pws_pkg::PH_BIT_MARK,
                                  fsk_pws_pkg::PH_END_MARK};
        r.tone_freq = mark ? mark_hz : space_hz;
        r.tone_is_mark = mark;
        r.busy_res = (line_phase != fsk_pws_pkg::PH_IDLE);
        r.accepted = took;
        expected_tones.push_back(r);
    endfunction

    function automatic int frame_span(input logic [1:0] kind, input logic [7:0] data,
                                      input logic last);
        int n;
        n = 0;
        if (kind == fsk_pws_pkg::KIND_BYTE)
        begin
            n = at_least_one(head_len) + at_least_one(gap_len);
            for (int b = 7; b >= 0; b--)
                n += (data[b] ? at_least_one(one_len) : at_least_one(zero_len))
                     + at_least_one(gap_len);
        end
        if (kind == fsk_pws_pkg::KIND_END || last)
            n += at_least_one(end_len) + at_least_one(end_gap_len);
        return n;
    endfunction

    task automatic push_word(input logic [1:0] kind, input logic [7:0] data, input logic last);
        tone_request_t w;
        w.kind = kind;
        w.data_byte = data;
        w.last_byte = last;
        request_queue.push_back(w);
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_word(fsk_pws_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic push_noise();
        push_word(2'($urandom_range(3)), 8'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        while (request_queue.size() != 0 || expected_tones.size() != 0)
            @(posedge clk);
    endtask

    task automatic finish_frame();
        wait_drained();
        while (line_phase != fsk_pws_pkg::PH_IDLE)
        begin
            push_ticks(ticks_left);
            wait_drained();
        end
    endtask

    task automatic set_reg(input logic [fsk_pws_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fsk_pws_pkg::FREQ_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            fsk_pws_pkg::CFG_HEAD_MARK:  head_len = value[fsk_pws_pkg::TICK_W-1:0];
            fsk_pws_pkg::CFG_GAP_SPACE:  gap_len = value[fsk_pws_pkg::TICK_W-1:0];
            fsk_pws_pkg::CFG_ONE_MARK:   one_len = value[fsk_pws_pkg::TICK_W-1:0];
            fsk_pws_pkg::CFG_ZERO_MARK:  zero_len = value[fsk_pws_pkg::TICK_W-1:0];
            fsk_pws_pkg::CFG_END_MARK:   end_len = value[fsk_pws_pkg::TICK_W-1:0];
            fsk_pws_pkg::CFG_END_SPACE:  end_gap_len = value[fsk_pws_pkg::TICK_W-1:0];
            fsk_pws_pkg::CFG_MARK_FREQ:  mark_hz = value;
            fsk_pws_pkg::CFG_SPACE_FREQ: space_hz = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // The upper bits of a length write carry noise; the block must drop them.
    task automatic load_settings(input logic [fsk_pws_pkg::TICK_W-1:0] h,
                                 input logic [fsk_pws_pkg::TICK_W-1:0] g,
                                 input logic [fsk_pws_pkg::TICK_W-1:0] o,
                                 input logic [fsk_pws_pkg::TICK_W-1:0] z,
                                 input logic [fsk_pws_pkg::TICK_W-1:0] em,
                                 input logic [fsk_pws_pkg::TICK_W-1:0] es,
                                 input logic [fsk_pws_pkg::FREQ_W-1:0] m,
                                 input logic [fsk_pws_pkg::FREQ_W-1:0] s);
        finish_frame();
        repeat (4) @(posedge clk);
        set_reg(fsk_pws_pkg::CFG_HEAD_MARK, {8'($urandom), h});
        set_reg(fsk_pws_pkg::CFG_GAP_SPACE, {8'($urandom), g});
        set_reg(fsk_pws_pkg::CFG_ONE_MARK, {8'($urandom), o});
        set_reg(fsk_pws_pkg::CFG_ZERO_MARK, {8'($urandom), z});
        set_reg(fsk_pws_pkg::CFG_END_MARK, {8'($urandom), em});
        set_reg(fsk_pws_pkg::CFG_END_SPACE, {8'($urandom), es});
        set_reg(fsk_pws_pkg::CFG_MARK_FREQ, m);
        set_reg(fsk_pws_pkg::CFG_SPACE_FREQ, s);
        setting_count++;
    endtask

    // Mostly whole frames with stray requests mixed in, sometimes plain noise.
    task automatic push_random(input int n_items);
        int         made;
        int         span;
        logic [1:0] k;
        logic [7:0] d;
        logic       l;
        made = 0;
        while (made < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                k = ($urandom_range(99) < 85) ? fsk_pws_pkg::KIND_BYTE : fsk_pws_pkg::KIND_END;
                d = 8'($urandom);
                l = 1'($urandom);
                push_word(k, d, l);
                made++;
                span = frame_span(k, d, l) + int'($urandom_range(4)) - 2;
                for (int i = 0; i < span; i++)
                begin
                    if ($urandom_range(99) < 8)
                        push_noise();
                    else
                        push_ticks(1);
                    made++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    push_noise();
                    made++;
                end
            end
        end
    endtask

    task automatic load_random_settings(input int max_len);
        load_settings(fsk_pws_pkg::TICK_W'($urandom_range(max_len)),
                      fsk_pws_pkg::TICK_W'($urandom_range(max_len)),
                      fsk_pws_pkg::TICK_W'($urandom_range(max_len)),
                      fsk_pws_pkg::TICK_W'($urandom_range(max_len)),
                      fsk_pws_pkg::TICK_W'($urandom_range(max_len)),
                      fsk_pws_pkg::TICK_W'($urandom_range(max_len)),
                      fsk_pws_pkg::FREQ_W'($urandom), fsk_pws_pkg::FREQ_W'($urandom));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        bit holding;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.kind <= fsk_pws_pkg::KIND_TICK;
            req_ch.data_byte <= 8'h00;
            req_ch.last_byte <= 1'b0;
        end
        else
        begin
            holding = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                predict_tone(req_ch.kind, req_ch.data_byte, req_ch.last_byte);
                void'(request_queue.pop_front());
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (request_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 16))
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.kind <= request_queue[0].kind;
                    req_ch.data_byte <= request_queue[0].data_byte;
                    req_ch.last_byte <= request_queue[0].last_byte;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : tone_monitor
        tone_result_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                words_checked++;
                if (expected_tones.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_tones.pop_front();
                    if (res_ch.tone_freq !== want.tone_freq)
                    begin
                        $error("tone_freq: expected %0d, got %0d", want.tone_freq,
                               res_ch.tone_freq);
                        fail_count++;
                    end
                    if (res_ch.tone_is_mark !== want.tone_is_mark)
                    begin
                        $error("tone_is_mark: expected %0b, got %0b", want.tone_is_mark,
                               res_ch.tone_is_mark);
                        fail_count++;
                    end
                    if (res_ch.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0b, got %0b", want.busy_res,
                               res_ch.busy_res);
                        fail_count++;
                    end
                    if (res_ch.accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0b, got %0b", want.accepted,
                               res_ch.accepted);
                        fail_count++;
                    end
                end
            end
            res_ch.ready <= no_gaps || ($urandom_range(99) >= 16);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = fsk_pws_pkg::CFG_HEAD_MARK;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = fsk_pws_pkg::KIND_TICK;
        req_ch.data_byte = 8'h00;
        req_ch.last_byte = 1'b0;
        res_ch.ready = 1'b0;
        no_gaps = 1'b0;
        head_len = fsk_pws_pkg::RST_HEAD_MARK;
        gap_len = fsk_pws_pkg::RST_GAP_SPACE;
        one_len = fsk_pws_pkg::RST_ONE_MARK;
        zero_len = fsk_pws_pkg::RST_ZERO_MARK;
        end_len = fsk_pws_pkg::RST_END_MARK;
        end_gap_len = fsk_pws_pkg::RST_END_SPACE;
        mark_hz = fsk_pws_pkg::RST_MARK_FREQ;
        space_hz = fsk_pws_pkg::RST_SPACE_FREQ;
        line_phase = fsk_pws_pkg::PH_IDLE;
        ticks_left = '0;
        bits_out = '0;
        bits_to_go = '0;
        end_after = 1'b0;
        setting_count = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: idle tick, unused kind, a byte with refused requests behind it.
        push_word(fsk_pws_pkg::KIND_TICK, 8'hFF, 1'b1);
        push_word(KIND_UNUSED, 8'h00, 1'b0);
        push_word(fsk_pws_pkg::KIND_BYTE, 8'h81, 1'b1);
        push_word(fsk_pws_pkg::KIND_BYTE, 8'h3C, 1'b0);
        push_word(fsk_pws_pkg::KIND_END, 8'h00, 1'b1);
        push_word(KIND_UNUSED, 8'hFF, 1'b1);
        finish_frame();

        // Zero and unit lengths, full-scale and zero tones, no idling on either side.
        load_settings(16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 24'hFFFFFF, 24'h000000);
        no_gaps = 1'b1;
        push_word(fsk_pws_pkg::KIND_END, 8'h55, 1'b1);
        push_word(fsk_pws_pkg::KIND_BYTE, 8'hFF, 1'b0);
        finish_frame();
        push_word(fsk_pws_pkg::KIND_BYTE, 8'hFF, 1'b1);
        push_word(fsk_pws_pkg::KIND_TICK, 8'h00, 1'b0);
        finish_frame();
        push_random(40);
        wait_drained();
        no_gaps = 1'b0;

        load_random_settings(4);
        push_random(25);
        wait_drained();
        push_random(25);

        load_random_settings(3);
        push_random(30);

        // Full-scale head length: the frame starts but is not run to its end.
        load_settings(16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd2, 16'hFFFF, 24'h800001, 24'hFFFFFF);
        push_word(fsk_pws_pkg::KIND_BYTE, 8'h96, 1'b1);
        push_word(fsk_pws_pkg::KIND_END, 8'h01, 1'b0);
        push_ticks(3);
        push_word(fsk_pws_pkg::KIND_BYTE, 8'h7E, 1'b1);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Checked %0d result words over %0d settings: %0d bytes and %0d end pulses,",
                 words_checked, setting_count, bytes_taken, ends_taken);
        $display("%0d requests refused while busy, lengths from zero to full scale.",
                 refused_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
